[hw/rtl/bd_pkg.sv]
// Shared types, constants and helper functions of the binary32 divider.
// Used by the front end, the operand queue, the back end and the top level.
package bd_pkg;

  localparam int unsigned MantSize  = 23;
  localparam int unsigned ExpSize   = 8;
  localparam int unsigned FSize     = 32;
  localparam int unsigned IntMant   = FSize - 2;
  localparam int unsigned RndBits   = IntMant - MantSize;
  localparam int unsigned ExpW      = 11;
  localparam int unsigned QueueDepth = 2;

  localparam logic [FSize-1:0] QNanBits = 32'h7FC0_0000;
  localparam logic [7:0]       ExpAll   = 8'hFF;

  typedef enum logic [2:0] {
    RM_RNE = 3'd0,
    RM_RTZ = 3'd1,
    RM_RDN = 3'd2,
    RM_RUP = 3'd3,
    RM_RMM = 3'd4
  } rmode_e;

  typedef struct packed {
    logic invalid;
    logic divide_zero;
    logic overflow;
    logic underflow;
    logic inexact;
  } fl_t;

  // One classified operand pair as it travels from the front to the back.
  typedef struct packed {
    logic                   special;
    logic                   sign;
    logic signed [ExpW-1:0] exp;
    logic [MantSize:0]      am;
    logic [MantSize:0]      bm;
    logic [FSize-1:0]       res;
    fl_t                    flags;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Left shift that brings the leading one of a subnormal significand to bit 23.
  function automatic logic [4:0] norm_shift(input logic [MantSize:0] m);
    logic [4:0] pos;
    pos = '0;
    for (int i = 0; i <= MantSize; i++) begin
      if (m[i]) pos = 5'(i);
    end
    return 5'(MantSize) - pos;
  endfunction

endpackage

[hw/rtl/binary32_divider.sv]
// Top level of the binary32 divider: configuration port, front end, operand
// queue and back end. Depends on bd_pkg, bd_front, bd_queue and bd_back.
//
// This block divides two IEEE 754 binary32 operands and returns the rounded
// quotient with the invalid, divide-by-zero, overflow, underflow and inexact
// flags of that one division; the caller ORs the flags into its accrued set.
// The rounding mode lives in register 0 of the APB port (byte address 0),
// reset to nearest-even, and should be written only while no division is in
// flight. One operand beat is accepted per clock while in_stall_o is low; it
// is classified in the front end, passes the operand queue and the restoring
// divider stages (one quotient bit per stage), and is then normalized and
// rounded into the output register. The back end moves as one pipeline that
// freezes while the output beat is stalled; the two-entry queue lets the
// front end keep accepting beats during such a stall until it fills.
module binary32_divider #(
  parameter int unsigned QueueDepth = bd_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] quotient_o,
  output logic        flag_invalid_o,
  output logic        flag_divide_zero_o,
  output logic        flag_overflow_o,
  output logic        flag_underflow_o,
  output logic        flag_inexact_o
);
  import bd_pkg::*;

  localparam logic RegRmode = 1'b0;

  // The rounding mode register. Bit 2 of the address selects the register
  // index; the low address bits are ignored.
  logic [2:0] rm_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegRmode) ? {29'd0, rm_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rm_q <= RM_RNE;
    end else if (psel && penable && pwrite && pready && (paddr[2] == RegRmode)) begin
      rm_q <= pwdata[2:0];
    end
  end

  logic      push, pop;
  op_t       f_op, q_op;
  q_status_t q_status;
  fl_t       flags;

  bd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .dividend_i (dividend_i),
    .divisor_i  (divisor_i),
    .push_o     (push),
    .q_status_i (q_status),
    .op_o       (f_op)
  );

  bd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_i  (f_op),
    .pop_i    (pop),
    .rdata_o  (q_op),
    .status_o (q_status)
  );

  bd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .op_i        (q_op),
    .pop_o       (pop),
    .rmode_i     (rm_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .quotient_o  (quotient_o),
    .flags_o     (flags)
  );

  assign flag_invalid_o     = flags.invalid;
  assign flag_divide_zero_o = flags.divide_zero;
  assign flag_overflow_o    = flags.overflow;
  assign flag_underflow_o   = flags.underflow;
  assign flag_inexact_o     = flags.inexact;

`ifndef SYNTHESIS
  // The queue can never report full and empty at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_status.full && q_status.empty))
    else $error("operand queue full and empty together");

  // An invalid operation always delivers the canonical quiet NaN.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && flag_invalid_o |-> quotient_o == QNanBits)
    else $error("invalid flag without canonical NaN");

  // Division by zero always delivers an infinity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && flag_divide_zero_o |-> quotient_o[30:0] == 31'h7F80_0000)
    else $error("divide by zero without infinity");

  // Overflow is always reported together with inexact.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && flag_overflow_o |-> flag_inexact_o)
    else $error("overflow without inexact");
`endif

endmodule

[hw/rtl/bd_front.sv]
// Front end: registers the operand beat, unpacks and classifies it, resolves
// special operands and normalizes subnormals. Depends on bd_pkg.
module bd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [31:0]         dividend_i,
  input  logic [31:0]         divisor_i,
  output logic                push_o,
  input  bd_pkg::q_status_t   q_status_i,
  output bd_pkg::op_t         op_o
);
  import bd_pkg::*;

  logic        valid_q, valid_d;
  logic [31:0] a_q, b_q;

  assign in_stall_o = valid_q && q_status_i.full;
  assign push_o     = valid_q && !q_status_i.full;

  always_comb begin
    valid_d = valid_q;
    if (push_o || !valid_q) valid_d = in_valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      a_q <= dividend_i;
      b_q <= divisor_i;
    end
  end

  always_comb begin
    logic [7:0]  ae, be;
    logic [22:0] af, bf;
    logic        a_nan, b_nan, a_snan, b_snan, a_zero, b_zero;
    logic [4:0]  sha, shb;
    logic signed [ExpW-1:0] ea, eb;
    ae = a_q[30:23];
    be = b_q[30:23];
    af = a_q[22:0];
    bf = b_q[22:0];
    ea = '0;
    eb = '0;
    a_nan  = (ae == ExpAll) && (af != '0);
    b_nan  = (be == ExpAll) && (bf != '0);
    a_snan = a_nan && !af[22];
    b_snan = b_nan && !bf[22];
    a_zero = (ae == '0) && (af == '0);
    b_zero = (be == '0) && (bf == '0);
    sha = norm_shift({1'b0, af});
    shb = norm_shift({1'b0, bf});

    op_o         = '0;
    op_o.sign    = a_q[31] ^ b_q[31];
    op_o.special = 1'b1;
    if (a_nan || b_nan) begin
      op_o.res           = QNanBits;
      op_o.flags.invalid = a_snan || b_snan;
    end else if (ae == ExpAll) begin
      if (be == ExpAll) begin
        op_o.res           = QNanBits;
        op_o.flags.invalid = 1'b1;
      end else begin
        op_o.res = {op_o.sign, ExpAll, 23'd0};
      end
    end else if (be == ExpAll) begin
      op_o.res = {op_o.sign, 31'd0};
    end else if (b_zero) begin
      if (a_zero) begin
        op_o.res           = QNanBits;
        op_o.flags.invalid = 1'b1;
      end else begin
        op_o.res               = {op_o.sign, ExpAll, 23'd0};
        op_o.flags.divide_zero = 1'b1;
      end
    end else if (a_zero) begin
      op_o.res = {op_o.sign, 31'd0};
    end else begin
      op_o.special = 1'b0;
      if (ae == '0) begin
        op_o.am = {1'b0, af} << sha;
        ea      = ExpW'(1) - ExpW'(sha);
      end else begin
        op_o.am = {1'b1, af};
        ea      = ExpW'(ae);
      end
      if (be == '0) begin
        op_o.bm = {1'b0, bf} << shb;
        eb      = ExpW'(1) - ExpW'(shb);
      end else begin
        op_o.bm = {1'b1, bf};
        eb      = ExpW'(be);
      end
      op_o.exp = ea - eb + ExpW'(127);
    end
  end

endmodule

[hw/rtl/bd_queue.sv]
// Short register queue between the front and back ends of the divider.
// Depends on bd_pkg for the entry and status types.
module bd_queue #(
  parameter int unsigned Depth = bd_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bd_pkg::op_t       wdata_i,
  input  logic              pop_i,
  output bd_pkg::op_t       rdata_o,
  output bd_pkg::q_status_t status_o
);
  import bd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  op_t             mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign status_o.full  = (cnt_q == CntW'(Depth));
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= wdata_i;
  end

endmodule

[hw/rtl/bd_back.sv]
// Back end: a restoring divider pipeline with one quotient bit per stage,
// followed by normalize/denormalize and round/pack stages. Depends on bd_pkg.
module bd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bd_pkg::q_status_t q_status_i,
  input  bd_pkg::op_t      op_i,
  output logic             pop_o,
  input  logic [2:0]       rmode_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [31:0]      quotient_o,
  output bd_pkg::fl_t      flags_o
);
  import bd_pkg::*;

  localparam int unsigned QBits = IntMant + 1;

  typedef struct packed {
    logic                   special;
    logic                   sign;
    logic signed [ExpW-1:0] exp;
    logic [MantSize:0]      bm;
    logic [MantSize+1:0]    rem;
    logic [QBits-1:0]       quo;
    logic [FSize-1:0]       res;
    fl_t                    flags;
  } div_t;

  logic en;
  logic [QBits:0] v_q;
  div_t           st_q [QBits+1];
  div_t           st_d [QBits+1];

  assign en    = !(out_valid_o && out_stall_i);
  assign pop_o = en && !q_status_i.empty;

  always_comb begin
    st_d[0]         = '0;
    st_d[0].special = op_i.special;
    st_d[0].sign    = op_i.sign;
    st_d[0].exp     = op_i.exp;
    st_d[0].bm      = op_i.bm;
    st_d[0].rem     = {1'b0, op_i.am};
    st_d[0].res     = op_i.res;
    st_d[0].flags   = op_i.flags;
  end

  for (genvar g = 0; g < QBits; g++) begin : g_step
    always_comb begin
      logic [MantSize+1:0] r;
      st_d[g+1] = st_q[g];
      r = (g == 0) ? st_q[g].rem : (st_q[g].rem << 1);
      if (r >= {1'b0, st_q[g].bm}) begin
        r = r - {1'b0, st_q[g].bm};
        st_d[g+1].quo[QBits-1-g] = 1'b1;
      end
      st_d[g+1].rem = r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[QBits-1:0], !q_status_i.empty};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i <= QBits; i++) st_q[i] <= st_d[i];
    end
  end

  // Normalize, decide tininess and shift subnormal results into place.
  logic                   a_v_q, a_special_q, a_sign_q, a_tiny_q, a_rne_q;
  logic signed [ExpW-1:0] a_exp_q;
  logic [QBits-1:0]       a_m_q;
  logic [RndBits-1:0]     a_add_q;
  logic [FSize-1:0]       a_res_q;
  fl_t                    a_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= v_q[QBits];
    end
  end

  always_ff @(posedge clk_i) begin
    logic [QBits-1:0]       qf;
    logic signed [ExpW-1:0] e, d;
    logic [RndBits-1:0]     addv;
    logic [FSize-1:0]       sum;
    logic [QBits-1:0]       mask;
    logic                   tiny;
    if (en) begin
      qf = st_q[QBits].quo | QBits'(st_q[QBits].rem != '0);
      e  = st_q[QBits].exp;
      if (!qf[QBits-1]) begin
        qf = qf << 1;
        e  = e - ExpW'(1);
      end
      case (rmode_i)
        RM_RNE, RM_RMM: addv = RndBits'(1) << (RndBits - 1);
        RM_RTZ:         addv = '0;
        default:        addv = (st_q[QBits].sign ^ rmode_i[0]) ? '1 : '0;
      endcase
      tiny = 1'b0;
      if (e <= 0) begin
        sum  = {1'b0, qf} + FSize'(addv);
        tiny = (e < 0) || !sum[FSize-1];
        d = ExpW'(1) - e;
        if (d >= ExpW'(QBits)) begin
          qf = QBits'(1);
        end else begin
          mask = (QBits'(1) << d[4:0]) - QBits'(1);
          qf   = (qf >> d[4:0]) | QBits'((qf & mask) != '0);
        end
        e = ExpW'(1);
      end
      a_tiny_q    <= tiny;
      a_special_q <= st_q[QBits].special;
      a_sign_q    <= st_q[QBits].sign;
      a_res_q     <= st_q[QBits].res;
      a_flags_q   <= st_q[QBits].flags;
      a_rne_q     <= (rmode_i == RM_RNE);
      a_add_q     <= addv;
      a_exp_q     <= e;
      a_m_q       <= qf;
    end
  end

  // Round, pack and hold the result beat.
  logic        o_v_q;
  logic [31:0] o_res_q;
  fl_t         o_flags_q;

  assign out_valid_o = o_v_q;
  assign quotient_o  = o_res_q;
  assign flags_o     = o_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (en) begin
      o_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [RndBits-1:0]     rb;
    logic [FSize-1:0]       sum;
    logic [MantSize+1:0]    mr;
    logic signed [ExpW-1:0] e2;
    fl_t                    fl;
    logic [31:0]            res;
    if (en) begin
      rb  = a_m_q[RndBits-1:0];
      sum = {1'b0, a_m_q} + FSize'(a_add_q);
      mr  = sum[FSize-1:RndBits];
      if (a_rne_q && (rb == (RndBits'(1) << (RndBits - 1)))) mr[0] = 1'b0;
      e2  = a_exp_q + ExpW'(mr[MantSize+1]);
      fl  = '0;
      fl.inexact   = (rb != '0);
      fl.underflow = a_tiny_q && (rb != '0);
      res = {a_sign_q, e2[7:0], mr[MantSize-1:0]};
      if (mr[MantSize+1:MantSize] == 2'b00) begin
        res = {a_sign_q, 8'd0, mr[MantSize-1:0]};
      end else if (e2 >= ExpW'(ExpAll)) begin
        res = (a_add_q == '0) ? {a_sign_q, 8'hFE, 23'h7FFFFF} : {a_sign_q, ExpAll, 23'd0};
        fl.overflow = 1'b1;
        fl.inexact  = 1'b1;
      end
      o_res_q   <= a_special_q ? a_res_q : res;
      o_flags_q <= a_special_q ? a_flags_q : fl;
    end
  end

endmodule
